// ===== src/bbpg_pkg.sv =====
`timescale 1ns / 1ps

package bbpg_pkg;

	localparam int LEN_W     = 15;
	localparam int COUNT_W   = 7;
	localparam int BEEP_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEN_W-1:0]   CYCLE_RESET    = 15'd200;
	localparam logic [LEN_W-1:0]   DUTY_RESET     = 15'd100;
	localparam logic [COUNT_W-1:0] ENDLESS_REPEAT = 7'd100;

	localparam logic [CFG_IDX_W-1:0] REG_CYCLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY  = 2'd1;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_ON    = 2'd2,
		FUNC_OFF   = 2'd3
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [COUNT_W-1:0] beep_count;
		logic [COUNT_W-1:0] pause_count;
		logic [COUNT_W-1:0] repeat_count;
	} in_item_t;

	typedef struct packed {
		logic buzzer_level;
		logic pattern_active;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] cycle_length;
		logic [LEN_W-1:0] duty_length;
	} cfg_t;

	typedef struct packed {
		logic [LEN_W-1:0]   tick_counter;
		logic [BEEP_W-1:0]  beep_index;
		logic [COUNT_W-1:0] repeat_index;
		logic [COUNT_W-1:0] active_beeps;
		logic [COUNT_W-1:0] pause_beeps;
		logic [COUNT_W-1:0] repeat_target;
		logic               drive_level;
	} pat_state_t;

endpackage

// ===== src/bbpg_step.sv =====
`timescale 1ns / 1ps

module bbpg_step (
	input  bbpg_pkg::pat_state_t cur,
	input  bbpg_pkg::cfg_t       cfg,
	input  bbpg_pkg::in_item_t   item,
	output bbpg_pkg::pat_state_t nxt
);
	import bbpg_pkg::*;

	logic [LEN_W-1:0]   tc;
	logic [BEEP_W-1:0]  bi;
	logic [BEEP_W-1:0]  group_len;
	logic [COUNT_W-1:0] ri;
	logic [COUNT_W-1:0] ab;

	assign group_len = {1'b0, cur.active_beeps} + {1'b0, cur.pause_beeps};

	always_comb begin
		nxt = cur;
		tc  = cur.tick_counter + 1'b1;
		bi  = cur.beep_index;
		ri  = cur.repeat_index;
		ab  = cur.active_beeps;
		case (item.func)
			FUNC_TICK: begin
				if (cur.active_beeps != '0) begin
					// drop the level once past the duty window
					if (cur.tick_counter >= cfg.duty_length &&
					    cur.tick_counter < cfg.cycle_length) begin
						nxt.drive_level = 1'b0;
					end
					if (tc >= cfg.cycle_length) begin
						tc = '0;
						bi = cur.beep_index + 1'b1;
						if (bi >= group_len) begin
							bi = '0;
							ri = cur.repeat_index + 1'b1;
							if (ri >= cur.repeat_target) begin
								ri = '0;
								if (cur.repeat_target < ENDLESS_REPEAT) begin
									ab = '0;
								end
							end
						end
					end
					// a stopped pattern has ab zero, so this stays off
					if (tc < cfg.duty_length && bi < {1'b0, ab}) begin
						nxt.drive_level = 1'b1;
					end
					nxt.tick_counter = tc;
					nxt.beep_index   = bi;
					nxt.repeat_index = ri;
					nxt.active_beeps = ab;
				end
			end
			FUNC_START: begin
				nxt.active_beeps  = item.beep_count;
				nxt.pause_beeps   = item.pause_count;
				nxt.repeat_target = item.repeat_count;
				nxt.beep_index    = '0;
				nxt.repeat_index  = '0;
			end
			FUNC_ON: begin
				nxt.active_beeps = '0;
				nxt.drive_level  = 1'b1;
			end
			default: begin
				nxt.active_beeps = '0;
				nxt.drive_level  = 1'b0;
			end
		endcase
	end

endmodule

// ===== src/buzzer_beep_pattern_generator.sv =====
`timescale 1ns / 1ps

// Buzzer pattern generator stepped by command words (tick, start, force on,
// force off). Each accepted word yields one result word (buzzer level and
// pattern-active flag) on the next cycle, and a new word is taken in every
// cycle: the pattern state update is one short pass of counter logic, and the
// output register takes the next word whenever it is empty or its current
// word is taken in the same cycle. The two length registers are written through
// the cfg port, index 0 cycle length and index 1 duty length; a write to either
// clears the tick counter. There is no start-up sweep; the block is ready out of reset.
module buzzer_beep_pattern_generator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  bbpg_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output bbpg_pkg::out_item_t                 out_data,
	input  logic                                cfg_we,
	input  logic [bbpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bbpg_pkg::LEN_W-1:0]          cfg_data
);
	import bbpg_pkg::*;

	cfg_t       cfg_q;
	pat_state_t state_q;
	pat_state_t state_nxt;
	pat_state_t state_d;
	out_item_t  out_q;
	logic       out_valid_q;
	logic       in_fire;
	logic       cfg_hit;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_hit   = cfg_we && (cfg_index == REG_CYCLE || cfg_index == REG_DUTY);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	bbpg_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (in_data),
		.nxt  (state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cycle_length <= CYCLE_RESET;
			cfg_q.duty_length  <= DUTY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CYCLE: cfg_q.cycle_length <= cfg_data;
				REG_DUTY:  cfg_q.duty_length  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = in_fire ? state_nxt : state_q;
		// a length write restarts the cycle count
		if (cfg_hit) begin
			state_d.tick_counter = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_q.buzzer_level   <= state_nxt.drive_level;
			out_q.pattern_active <= (state_nxt.active_beeps != '0);
		end
	end

`ifndef ASSERT_OFF
	a_cfg_clears_tick: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> state_q.tick_counter == '0)
		else $error("tick counter not cleared by length write");

	a_active_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_q.pattern_active == (state_q.active_beeps != '0))
		else $error("pattern_active disagrees with pattern state");

	a_level_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> out_q.buzzer_level == state_q.drive_level)
		else $error("buzzer_level disagrees with drive state");

	a_force_on: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.func == FUNC_ON |=> out_q.buzzer_level && !out_q.pattern_active)
		else $error("force on did not stop pattern with buzzer on");

	a_tick_in_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && in_data.func == FUNC_TICK && state_q.active_beeps != '0 && !cfg_we
		|=> state_q.tick_counter < cfg_q.cycle_length || cfg_q.cycle_length == '0)
		else $error("tick counter ran past cycle length");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import bbpg_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_WORDS = 140;
	localparam int PHASES      = 10;
	localparam int LONG_HOLD   = 300;
	localparam int HOLD_AT     = 60;

	// indexes that map to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	in_item_t             in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEN_W-1:0]     cfg_data = '0;

	buzzer_beep_pattern_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the pattern generator
	logic [LEN_W-1:0] cycle_len = CYCLE_RESET;
	logic [LEN_W-1:0] duty_len  = DUTY_RESET;
	pat_state_t       pat = '0;

	in_item_t  cmd_q[$];
	out_item_t level_q[$];
	int        issued = 0;
	int        accepted = 0;
	int        errors = 0;
	int        cycles = 0;
	int        tx_wait = 0;
	int        tx_calm = 0;
	int        rx_stall = 0;
	int        rx_calm = 0;
	bit        hold_done = 1'b0;

	function automatic out_item_t step_pattern(in_item_t w);
		out_item_t r;
		case (w.func)
			FUNC_TICK: begin
				if (pat.active_beeps != '0) begin
					if (pat.tick_counter >= duty_len && pat.tick_counter < cycle_len)
						pat.drive_level = 1'b0;
					pat.tick_counter = pat.tick_counter + 1'b1;
					if (pat.tick_counter >= cycle_len) begin
						pat.tick_counter = '0;
						pat.beep_index = pat.beep_index + 1'b1;
						if (int'(pat.beep_index) >=
						    int'(pat.active_beeps) + int'(pat.pause_beeps)) begin
							pat.beep_index = '0;
							pat.repeat_index = pat.repeat_index + 1'b1;
							if (pat.repeat_index >= pat.repeat_target) begin
								pat.repeat_index = '0;
								if (pat.repeat_target < ENDLESS_REPEAT)
									pat.active_beeps = '0;
							end
						end
					end
					if (pat.tick_counter < duty_len &&
					    int'(pat.beep_index) < int'(pat.active_beeps))
						pat.drive_level = 1'b1;
				end
			end
			FUNC_START: begin
				pat.active_beeps  = w.beep_count;
				pat.pause_beeps   = w.pause_count;
				pat.repeat_target = w.repeat_count;
				pat.beep_index    = '0;
				pat.repeat_index  = '0;
			end
			FUNC_ON: begin
				pat.active_beeps = '0;
				pat.drive_level  = 1'b1;
			end
			default: begin
				pat.active_beeps = '0;
				pat.drive_level  = 1'b0;
			end
		endcase
		r.buzzer_level   = pat.drive_level;
		r.pattern_active = (pat.active_beeps != '0);
		return r;
	endfunction

	// mostly short gaps, a few long ones, and now and then a calm stretch
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (tx_wait > 0) begin
				tx_wait--;
				in_valid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				in_data  <= cmd_q.pop_front();
				in_valid <= 1'b1;
				tx_wait = pick_gap(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// stall the receiver early so the block backs up its input
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!hold_done && accepted >= HOLD_AT) begin
			hold_done = 1'b1;
			rx_stall = LONG_HOLD;
			out_ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			out_ready <= 1'b0;
		end else begin
			rx_stall = pick_gap(rx_calm);
			out_ready <= (rx_stall == 0);
		end
	end

	always @(posedge clk) begin : mon
		out_item_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CYCLE: begin
						cycle_len = cfg_data;
						pat.tick_counter = '0;
					end
					REG_DUTY: begin
						duty_len = cfg_data;
						pat.tick_counter = '0;
					end
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				level_q.push_back(step_pattern(in_data));
				accepted++;
			end
			if (out_valid && out_ready) begin
				if (level_q.size() == 0) begin
					$display("%0t: unexpected word, expected none actual %b", $time, out_data);
					errors++;
				end else begin
					want = level_q.pop_front();
					if (out_data.buzzer_level !== want.buzzer_level) begin
						$display("%0t: buzzer_level expected %0b actual %0b",
							$time, want.buzzer_level, out_data.buzzer_level);
						errors++;
					end
					if (out_data.pattern_active !== want.pattern_active) begin
						$display("%0t: pattern_active expected %0b actual %0b",
							$time, want.pattern_active, out_data.pattern_active);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("buzzer_beep_pattern_generator verification failed");
			$finish;
		end
	end

	task automatic queue_word(in_item_t w);
		cmd_q.push_back(w);
		issued++;
	endtask

	task automatic queue_cmd(func_t f, int beeps, int pauses, int repeats);
		in_item_t w;
		w.func         = f;
		w.beep_count   = beeps[COUNT_W-1:0];
		w.pause_count  = pauses[COUNT_W-1:0];
		w.repeat_count = repeats[COUNT_W-1:0];
		queue_word(w);
	endtask

	task automatic wait_idle();
		while (accepted != issued || level_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// a start, then a run of ticks with an occasional forced level
	task automatic queue_pattern_run();
		in_item_t w;
		int n;
		w = in_item_t'($urandom);
		w.func = FUNC_START;
		if ($urandom_range(0, 4) != 0) begin
			w.beep_count  = COUNT_W'($urandom_range(0, 3));
			w.pause_count = COUNT_W'($urandom_range(0, 2));
			w.repeat_count = COUNT_W'(($urandom_range(0, 3) == 0) ?
				$urandom_range(100, 127) : $urandom_range(0, 3));
		end
		queue_word(w);
		n = $urandom_range(3, 40);
		repeat (n) begin
			w = in_item_t'($urandom);
			if ($urandom_range(0, 19) == 0)
				w.func = ($urandom_range(0, 1) == 0) ? FUNC_ON : FUNC_OFF;
			else
				w.func = FUNC_TICK;
			queue_word(w);
		end
	endtask

	logic [LEN_W-1:0] phase_cycle[PHASES] = '{15'd3, 15'd0, 15'd1, 15'd5, 15'd32767,
		15'd0, 15'd32767, 15'd200, 15'd2, 15'd6};
	logic [LEN_W-1:0] phase_duty[PHASES] = '{15'd1, 15'd0, 15'd1, 15'd9, 15'd32767,
		15'd32767, 15'd0, 15'd100, 15'd2, 15'd3};

	initial begin
		int base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_CYCLE, 15'd4);
		write_reg(REG_DUTY, 15'd2);

		queue_cmd(FUNC_TICK, 0, 0, 0);
		queue_cmd(FUNC_ON, 127, 127, 127);
		queue_cmd(FUNC_TICK, 0, 0, 0);
		// zero beeps keeps the forced level
		queue_cmd(FUNC_START, 0, 127, 127);
		queue_cmd(FUNC_TICK, 0, 0, 0);
		queue_cmd(FUNC_OFF, 0, 0, 0);
		queue_cmd(FUNC_START, 2, 1, 1);
		repeat (12) queue_cmd(FUNC_TICK, 0, 0, 0);
		// repeat count of zero ends after one group
		queue_cmd(FUNC_START, 1, 0, 0);
		repeat (4) queue_cmd(FUNC_TICK, 0, 0, 0);
		queue_cmd(FUNC_START, 127, 127, 127);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_CYCLE, phase_cycle[p]);
			write_reg(REG_DUTY, phase_duty[p]);
			if (p == 3) begin
				write_reg(REG_SPARE_LO, 15'h7fff);
				write_reg(REG_SPARE_HI, 15'h5555);
			end
			base = issued;
			while (issued - base < PHASE_WORDS) begin
				if ($urandom_range(0, 3) != 0)
					queue_pattern_run();
				else
					queue_word(in_item_t'($urandom));
			end
			wait_idle();
		end

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("buzzer_beep_pattern_generator verification clean");
		else
			$display("buzzer_beep_pattern_generator verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
src/bbpg_pkg.sv
src/bbpg_step.sv
src/buzzer_beep_pattern_generator.sv
dv/tb.sv
